### rtl/core/cmrf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cmrf_pkg;

  localparam int MAX_WIDTH_DEF = 2048;
  localparam int DIM_MIN       = 3;
  localparam int DIM_MAX       = 2048;

  localparam int CFG_W     = 12;
  localparam int COORD_W   = 11;
  localparam int CHAN_W    = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd1920;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd1080;

  localparam int OFIFO_DEPTH = 4;
  localparam int OFIFO_PTR_W = $clog2(OFIFO_DEPTH);
  localparam int OFIFO_CNT_W = $clog2(OFIFO_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } pix_t;

  typedef struct packed {
    pix_t               pix;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               frame_end;
  } result_t;

  // one accepted transaction, as held in the compute stage
  typedef struct packed {
    pix_t               cur;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               row0;
    logic               above;
    logic               last_row;
    logic               last_col;
    logic               border;
  } stage_t;

endpackage

`default_nettype wire

### rtl/core/cmrf_line_buf.sv
`timescale 1ns / 1ps
`default_nettype none

module cmrf_line_buf
  import cmrf_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  input  pix_t          mid_wdata,
  input  logic          up_we,
  input  logic [AW-1:0] up_waddr,
  input  pix_t          up_wdata,
  output pix_t          centre_q,
  output pix_t          right_q,
  output pix_t          up_q
);

  pix_t mid_mem [MAX_WIDTH];
  pix_t up_mem  [MAX_WIDTH];

  logic [AW-1:0] rd_addr_p1;

  assign rd_addr_p1 = rd_addr + 1'b1;

  // read-first: the centre read sees the previous row before the new pixel lands
  always_ff @(posedge clk) begin
    if (rd_en) begin
      centre_q         <= mid_mem[rd_addr];
      right_q          <= mid_mem[rd_addr_p1];
      mid_mem[rd_addr] <= mid_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      up_q <= up_mem[rd_addr];
    end
    if (up_we) begin
      up_mem[up_waddr] <= up_wdata;
    end
  end

endmodule

`default_nettype wire

### rtl/core/cmrf_kernel.sv
`timescale 1ns / 1ps
`default_nettype none

module cmrf_kernel
  import cmrf_pkg::*;
(
  input  logic    stg_valid,
  input  stage_t  stg,
  input  pix_t    centre,
  input  pix_t    left,
  input  pix_t    right,
  input  pix_t    up,
  output result_t res0,
  output result_t res1,
  output logic [1:0] push_n
);

  // floor(s / 5) for s <= 1275 by reciprocal multiply
  function automatic logic [CHAN_W-1:0] div5(input logic [10:0] s);
    logic [26:0] p;
    p = 27'(s) * 27'(52429);
    return p[25:18];
  endfunction

  function automatic logic [CHAN_W-1:0] mean_ch(
    input logic [CHAN_W-1:0] a,
    input logic [CHAN_W-1:0] b,
    input logic [CHAN_W-1:0] c,
    input logic [CHAN_W-1:0] d,
    input logic [CHAN_W-1:0] e
  );
    logic [10:0] s;
    s = 11'(a) + 11'(b) + 11'(c) + 11'(d) + 11'(e);
    return div5(s);
  endfunction

  pix_t    mean;
  result_t first;
  result_t last;
  logic    have_first;

  always_comb begin
    mean.r = mean_ch(centre.r, left.r, right.r, up.r, stg.cur.r);
    mean.g = mean_ch(centre.g, left.g, right.g, up.g, stg.cur.g);
    mean.b = mean_ch(centre.b, left.b, right.b, up.b, stg.cur.b);

    first.col       = stg.col;
    first.frame_end = 1'b0;
    if (stg.row0) begin
      first.pix = stg.cur;
      first.row = stg.row;
    end else begin
      first.pix = stg.border ? centre : mean;
      first.row = stg.row - 1'b1;
    end

    last.pix       = stg.cur;
    last.col       = stg.col;
    last.row       = stg.row;
    last.frame_end = stg.last_col;

    have_first = stg.row0 | stg.above;
    res0       = have_first ? first : last;
    res1       = last;
    push_n     = stg_valid ? (2'(have_first) + 2'(stg.last_row)) : 2'd0;
  end

endmodule

`default_nettype wire

### rtl/core/cmrf_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module cmrf_out_fifo
  import cmrf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [1:0]             push_n,
  input  result_t                push0,
  input  result_t                push1,
  output logic [OFIFO_CNT_W-1:0] count,
  output logic                   out_valid,
  input  logic                   out_ready,
  output result_t                head
);

  result_t                entry_r [OFIFO_DEPTH];
  logic [OFIFO_PTR_W-1:0] wr_r;
  logic [OFIFO_PTR_W-1:0] wr_nxt;
  logic [OFIFO_PTR_W-1:0] rd_r;
  logic [OFIFO_PTR_W-1:0] rd_nxt;
  logic [OFIFO_CNT_W-1:0] cnt_r;
  logic [OFIFO_CNT_W-1:0] cnt_nxt;
  logic [OFIFO_PTR_W-1:0] wr_p1;
  logic                   pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != '0);
  assign head      = entry_r[rd_r];
  assign count     = cnt_r;
  assign wr_p1     = wr_r + 1'b1;

  always_comb begin
    wr_nxt  = wr_r + OFIFO_PTR_W'(push_n);
    rd_nxt  = rd_r + OFIFO_PTR_W'(pop);
    cnt_nxt = cnt_r + OFIFO_CNT_W'(push_n) - OFIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entry_r[wr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      entry_r[wr_p1] <= push1;
    end
  end

endmodule

`default_nettype wire

### rtl/core/cross_mean_rgb_filter.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake             Payload
// in_       in_valid / in_ready   in_red, in_green, in_blue
// out_      out_valid / out_ready out_red, out_green, out_blue, out_pixel_column,
//                                 out_pixel_row, out_frame_end
// cfg_      cfg_we                cfg_index, cfg_data
//
// One pixel per cycle while in_ready is high; a result passes the stage register and
// then the result queue before it leaves. Last-row pixels make two results each, so
// there the single output port sets the pace.
// in_ready drops when the 4-entry result queue could not take the next results.
// Reset clears counters and queue and loads the default config; line stores are not cleared.

module cross_mean_rgb_filter
  import cmrf_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CHAN_W-1:0]    in_red,
  input  logic [CHAN_W-1:0]    in_green,
  input  logic [CHAN_W-1:0]    in_blue,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CHAN_W-1:0]    out_red,
  output logic [CHAN_W-1:0]    out_green,
  output logic [CHAN_W-1:0]    out_blue,
  output logic [COORD_W-1:0]   out_pixel_column,
  output logic [COORD_W-1:0]   out_pixel_row,
  output logic                 out_frame_end,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WidthLim = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;

  logic [CFG_W-1:0]   frame_width_r;
  logic [CFG_W-1:0]   frame_height_r;
  logic [COORD_W-1:0] col_r;
  logic [COORD_W-1:0] col_nxt;
  logic [COORD_W-1:0] row_r;
  logic [COORD_W-1:0] row_nxt;
  stage_t             stg_r;
  stage_t             stg_nxt;
  logic               stg_v_r;
  logic [AW-1:0]      ci_r;
  pix_t               left_r;

  logic [CFG_W-1:0]       eff_w;
  logic [CFG_W-1:0]       eff_h;
  logic                   last_col;
  logic                   last_row;
  logic [AW-1:0]          ci;
  logic                   accept;
  pix_t                   cur;
  pix_t                   centre_q;
  pix_t                   right_q;
  pix_t                   up_q;
  result_t                res0;
  result_t                res1;
  result_t                head;
  logic [1:0]             push_n;
  logic [OFIFO_CNT_W-1:0] fifo_cnt;

  assign cur    = '{r: in_red, g: in_green, b: in_blue};
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width_r < CFG_W'(DIM_MIN)) begin
      eff_w = CFG_W'(DIM_MIN);
    end else if (frame_width_r > CFG_W'(WidthLim)) begin
      eff_w = CFG_W'(WidthLim);
    end else begin
      eff_w = frame_width_r;
    end
    if (frame_height_r < CFG_W'(DIM_MIN)) begin
      eff_h = CFG_W'(DIM_MIN);
    end else if (frame_height_r > CFG_W'(DIM_MAX)) begin
      eff_h = CFG_W'(DIM_MAX);
    end else begin
      eff_h = frame_height_r;
    end

    last_col = CFG_W'(col_r) >= (eff_w - 1'b1);
    last_row = CFG_W'(row_r) >= (eff_h - 1'b1);

    if (32'(col_r) >= 32'(MAX_WIDTH)) begin
      ci = AW'(MAX_WIDTH - 1);
    end else begin
      ci = AW'(col_r);
    end

    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + 1'b1;
    end else begin
      col_nxt = col_r + 1'b1;
      row_nxt = row_r;
    end

    stg_nxt.cur      = cur;
    stg_nxt.col      = col_r;
    stg_nxt.row      = row_r;
    stg_nxt.row0     = (row_r == '0);
    stg_nxt.above    = (row_r >= COORD_W'(2));
    stg_nxt.last_row = last_row;
    stg_nxt.last_col = last_col;
    stg_nxt.border   = (col_r == '0) || last_col;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= accept;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  // left neighbor is the previous transaction's centre, already moved to the upper row
  always_ff @(posedge clk) begin
    if (accept) begin
      stg_r  <= stg_nxt;
      ci_r   <= ci;
      left_r <= centre_q;
    end
  end

  cmrf_line_buf #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_buf (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr   (ci),
    .mid_wdata (cur),
    .up_we     (stg_v_r),
    .up_waddr  (ci_r),
    .up_wdata  (centre_q),
    .centre_q  (centre_q),
    .right_q   (right_q),
    .up_q      (up_q)
  );

  cmrf_kernel u_kernel (
    .stg_valid (stg_v_r),
    .stg       (stg_r),
    .centre    (centre_q),
    .left      (left_r),
    .right     (right_q),
    .up        (up_q),
    .res0      (res0),
    .res1      (res1),
    .push_n    (push_n)
  );

  cmrf_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (push_n),
    .push0     (res0),
    .push1     (res1),
    .count     (fifo_cnt),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head)
  );

  // room for what is in flight plus the worst case of the next transaction
  assign in_ready = (4'(fifo_cnt) + 4'(push_n) + 4'd2) <= 4'(OFIFO_DEPTH);

  assign out_red          = head.pix.r;
  assign out_green        = head.pix.g;
  assign out_blue         = head.pix.b;
  assign out_pixel_column = head.col;
  assign out_pixel_row    = head.row;
  assign out_frame_end    = head.frame_end;

endmodule

`default_nettype wire

### rtl/core/cmrf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module cmrf_checker
  import cmrf_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [CHAN_W-1:0]    out_red,
  input logic [CHAN_W-1:0]    out_green,
  input logic [CHAN_W-1:0]    out_blue,
  input logic [COORD_W-1:0]   out_pixel_column,
  input logic [COORD_W-1:0]   out_pixel_row,
  input logic                 out_frame_end
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid
      && $stable({out_red, out_green, out_blue, out_pixel_column, out_pixel_row,
                  out_frame_end}))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result presented right after reset");

  a_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_pixel_column >= 2 && out_pixel_row >= 2)
    else $error("frame end away from the bottom-right corner");

  a_new_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_frame_end
      |=> !out_valid || (out_pixel_row == '0 && out_pixel_column == '0))
    else $error("next frame does not start at the origin");

endmodule

bind cross_mean_rgb_filter cmrf_checker u_cmrf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_red          (out_red),
  .out_green        (out_green),
  .out_blue         (out_blue),
  .out_pixel_column (out_pixel_column),
  .out_pixel_row    (out_pixel_row),
  .out_frame_end    (out_frame_end)
);

`default_nettype wire

### verif/cross_mean_rgb_filter_tb.sv
`timescale 1ns / 1ps

module cross_mean_rgb_filter_tb;
  import cmrf_pkg::*;

  localparam int TAPS         = 5;
  localparam int CHANNELS     = 3;
  localparam int RANDOM_ITEMS = 1850;
  localparam int CALM_ITEMS   = 300;
  localparam int SETTLE       = 12;
  localparam int CYCLE_LIMIT  = 3000000;

  typedef enum int {FILL_RANDOM, FILL_SATURATED, FILL_RAMP} fill_e;

  class cross_mean_board;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    pix_t             upper_row [MAX_WIDTH_DEF];
    pix_t             middle_row [MAX_WIDTH_DEF];
    int unsigned      col;
    int unsigned      row;
    result_t          due_pixels [$];
    int               errors;

    function new();
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      col        = 0;
      row        = 0;
      errors     = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_W-1:0] v);
      case (idx)
        REG_FRAME_WIDTH:  width_reg = v;
        REG_FRAME_HEIGHT: height_reg = v;
        default: ;
      endcase
    endfunction

    function int unsigned active_width();
      int unsigned lim;
      int unsigned w;
      lim = (MAX_WIDTH_DEF < DIM_MAX) ? MAX_WIDTH_DEF : DIM_MAX;
      w = width_reg;
      if (w < DIM_MIN) w = DIM_MIN;
      if (w > lim) w = lim;
      return w;
    endfunction

    function int unsigned active_height();
      int unsigned h;
      h = height_reg;
      if (h < DIM_MIN) h = DIM_MIN;
      if (h > DIM_MAX) h = DIM_MAX;
      return h;
    endfunction

    function pix_t cross_mean(pix_t ctr, pix_t lft, pix_t rgt, pix_t up, pix_t dn);
      pix_t        m;
      logic [10:0] s;
      for (int k = 0; k < CHANNELS; k++) begin
        s = 11'(ctr[k*8 +: 8]) + 11'(lft[k*8 +: 8]) + 11'(rgt[k*8 +: 8])
          + 11'(up[k*8 +: 8]) + 11'(dn[k*8 +: 8]);
        m[k*8 +: 8] = 8'(s / TAPS);
      end
      return m;
    endfunction

    // stores: below col the current row / row above, from col on the row above / two above
    function void take_pixel(pix_t cur);
      int unsigned w;
      int unsigned h;
      bit          last_col;
      bit          last_row;
      pix_t        pix;
      w = active_width();
      h = active_height();
      last_col = col >= w - 1;
      last_row = row >= h - 1;
      if (row == 0) begin
        due_pixels.push_back(result_t'{pix: cur, col: 11'(col), row: 11'(row), frame_end: 1'b0});
      end else if (row >= 2) begin
        if (col == 0 || last_col) begin
          pix = middle_row[col];
        end else begin
          pix = cross_mean(middle_row[col], upper_row[col-1], middle_row[col+1],
                           upper_row[col], cur);
        end
        due_pixels.push_back(result_t'{pix: pix, col: 11'(col), row: 11'(row - 1),
                                       frame_end: 1'b0});
      end
      if (last_row) begin
        due_pixels.push_back(result_t'{pix: cur, col: 11'(col), row: 11'(row),
                                       frame_end: last_col});
      end
      upper_row[col]  = middle_row[col];
      middle_row[col] = cur;
      if (last_col) begin
        col = 0;
        row = last_row ? 0 : row + 1;
      end else begin
        col++;
      end
    endfunction

    function string show(result_t x);
      return $sformatf("rgb=%0d/%0d/%0d col=%0d row=%0d end=%0b",
                       x.pix.r, x.pix.g, x.pix.b, x.col, x.row, x.frame_end);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (due_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual %s", $time, show(got));
        return;
      end
      want = due_pixels.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: mismatch, expected %s actual %s", $time, show(want), show(got));
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CHAN_W-1:0]    in_red = '0;
  logic [CHAN_W-1:0]    in_green = '0;
  logic [CHAN_W-1:0]    in_blue = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CHAN_W-1:0]    out_red;
  logic [CHAN_W-1:0]    out_green;
  logic [CHAN_W-1:0]    out_blue;
  logic [COORD_W-1:0]   out_pixel_column;
  logic [COORD_W-1:0]   out_pixel_row;
  logic                 out_frame_end;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  cross_mean_board board = new();

  bit quiet = 1'b0;
  int in_gap_odds = 0;
  int out_gap_odds = 0;
  int stall_left = 0;
  int cycles = 0;

  cross_mean_rgb_filter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_pixel_column (out_pixel_column),
    .out_pixel_row    (out_pixel_row),
    .out_frame_end    (out_frame_end),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && out_gap_odds != 0 && $urandom_range(1, 8) <= out_gap_odds) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_result(result_t'{pix: pix_t'{r: out_red, g: out_green, b: out_blue},
                                   col: out_pixel_column, row: out_pixel_row,
                                   frame_end: out_frame_end});
  end

  function automatic logic [CHAN_W-1:0] random_chan();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pix_t pick_pixel(fill_e fill, int i);
    pix_t p;
    case (fill)
      FILL_SATURATED: p = '{r: 8'd255, g: 8'd0, b: (i == 4) ? 8'd0 : 8'd255};
      FILL_RAMP:      p = '{r: 8'(i * 61), g: 8'(255 - i * 29), b: 8'(i * i * 7)};
      default:        p = '{r: random_chan(), g: random_chan(), b: random_chan()};
    endcase
    return p;
  endfunction

  task automatic send_pixel(pix_t p);
    int gap;
    if (!quiet && in_gap_odds != 0 && $urandom_range(1, 8) <= in_gap_odds) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 9);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= p.r;
    in_green <= p.g;
    in_blue  <= p.b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.take_pixel(p);
  endtask

  task automatic drain();
    while (board.due_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    board.write_reg(REG_FRAME_WIDTH, w);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    board.write_reg(REG_FRAME_HEIGHT, h);
    cfg_we <= 1'b0;
  endtask

  task automatic run_frame(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, fill_e fill,
                           output int sent);
    int total;
    drain();
    set_frame(w, h);
    total = board.active_width() * board.active_height();
    for (int i = 0; i < total; i++) send_pixel(pick_pixel(fill, i));
    in_valid <= 1'b0;
    sent = total;
  endtask

  function automatic logic [CFG_W-1:0] random_dim(int hi);
    case ($urandom_range(0, 9))
      0: return CFG_W'($urandom_range(0, 3));
      1: return CFG_W'($urandom_range(hi + 1, 48));
      default: return CFG_W'($urandom_range(3, hi));
    endcase
  endfunction

  initial begin
    int fed;
    int frames;
    int sent;
    fed = 0;
    frames = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    run_frame(12'd3, 12'd3, FILL_SATURATED, sent);
    run_frame(12'd0, 12'd4, FILL_RAMP, sent);

    while (fed < RANDOM_ITEMS) begin
      quiet = fed >= RANDOM_ITEMS - CALM_ITEMS;
      in_gap_odds  = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) != 0) ? 1 : 4);
      out_gap_odds = ($urandom_range(0, 2) == 0) ? 0 : (($urandom_range(0, 1) != 0) ? 1 : 4);
      if (frames == 2) begin
        run_frame(12'd2, 12'd0, FILL_RANDOM, sent);
      end else if (frames == 5) begin
        run_frame(12'd1, 12'd2, FILL_RANDOM, sent);
      end else begin
        run_frame(random_dim(20), random_dim(8), FILL_RANDOM, sent);
      end
      fed += sent;
      frames++;
    end

    while (board.due_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (board.errors == 0 && board.due_pixels.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
